>>> hdl/rti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_pkg
// Widths, register indexes and stage types of the ray/triangle intersector.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int unsigned CoordFracBits = 16;
  localparam int unsigned EpsShift      = 20;

  localparam int unsigned CW  = 32;             // coordinate
  localparam int unsigned EW  = CW + 1;         // edge and offset vectors
  localparam int unsigned HW  = 2 * EW + 1;     // cross product terms
  localparam int unsigned LW  = EW;             // low slice of a split operand
  localparam int unsigned PW  = HW;             // partial product
  localparam int unsigned WW  = 104;            // determinant and dot products
  localparam int unsigned NW  = WW + CoordFracBits;
  localparam int unsigned QTW = 63;             // quotient t, unsigned
  localparam int unsigned TLW = 32;             // low slice of t
  localparam int unsigned MLW = TLW + 1 + CW;   // low t partial
  localparam int unsigned MHW = QTW - TLW + 1 + CW;
  localparam int unsigned PTW = QTW + 1 + CW + 1;

  localparam int unsigned IdxA = 0;
  localparam int unsigned IdxU = 1;
  localparam int unsigned IdxV = 2;
  localparam int unsigned IdxT = 3;

  // accept to result strobe, in cycles
  localparam int unsigned Latency = 7 + 1 + QTW + 2;

  typedef enum logic [2:0] {
    CfgOrgX   = 3'd0,
    CfgOrgY   = 3'd1,
    CfgOrgZ   = 3'd2,
    CfgDirX   = 3'd3,
    CfgDirY   = 3'd4,
    CfgDirZ   = 3'd5,
    CfgAlgSel = 3'd6,
    CfgNone   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic           hit;
    logic           sat;
    logic [WW-1:0]  a;
    logic [WW-1:0]  r;
    logic [QTW-1:0] nlo;
    logic [QTW-1:0] quo;
  } div_t;

endpackage

>>> hdl/ray_triangle_intersect_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_top
// Pipelined Moller-Trumbore test of one triangle per cycle against the ray
// held in configuration; one hit flag and saturated hit point per item.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------
//   triangle | start, busy                | v0_*_i, v1_*_i, v2_*_i
//   result   | done_o strobe, one cycle   | hit_o, hit_x_o, hit_y_o, hit_z_o
//   config   | cfg_valid_i, cfg_ready_o   | cfg_index_i, cfg_data_i
//
// one item per cycle; most of the pipeline from accept to result is the
// 63-stage restoring divider that forms t, one quotient bit per stage. busy is
// never raised and the pipeline never stalls.
// reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [rti_pkg::CW-1:0] v0_x_i,
  input  logic signed [rti_pkg::CW-1:0] v0_y_i,
  input  logic signed [rti_pkg::CW-1:0] v0_z_i,
  input  logic signed [rti_pkg::CW-1:0] v1_x_i,
  input  logic signed [rti_pkg::CW-1:0] v1_y_i,
  input  logic signed [rti_pkg::CW-1:0] v1_z_i,
  input  logic signed [rti_pkg::CW-1:0] v2_x_i,
  input  logic signed [rti_pkg::CW-1:0] v2_y_i,
  input  logic signed [rti_pkg::CW-1:0] v2_z_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic signed [rti_pkg::CW-1:0] hit_x_o,
  output logic signed [rti_pkg::CW-1:0] hit_y_o,
  output logic signed [rti_pkg::CW-1:0] hit_z_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [2:0]                   cfg_index_i,
  input  logic [rti_pkg::CW-1:0]       cfg_data_i
);
  import rti_pkg::*;

  // configuration
  logic signed [CW-1:0] org_q [3];
  logic signed [CW-1:0] dir_q [3];
  logic                 alg_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= CW'(1 << CoordFracBits);
      dir_q[1] <= '0;
      dir_q[2] <= '0;
      alg_q    <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgOrgX:   org_q[0] <= cfg_data_i;
        CfgOrgY:   org_q[1] <= cfg_data_i;
        CfgOrgZ:   org_q[2] <= cfg_data_i;
        CfgDirX:   dir_q[0] <= cfg_data_i;
        CfgDirY:   dir_q[1] <= cfg_data_i;
        CfgDirZ:   dir_q[2] <= cfg_data_i;
        CfgAlgSel: alg_q    <= cfg_data_i[0];
        CfgNone:   ;
        default:   ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  logic signed [CW-1:0] v0 [3];
  logic signed [CW-1:0] v1 [3];
  logic signed [CW-1:0] v2 [3];
  assign v0[0] = v0_x_i;  assign v0[1] = v0_y_i;  assign v0[2] = v0_z_i;
  assign v1[0] = v1_x_i;  assign v1[1] = v1_y_i;  assign v1[2] = v1_z_i;
  assign v2[0] = v2_x_i;  assign v2[1] = v2_y_i;  assign v2[2] = v2_z_i;

  logic signed [EW-1:0] dext [3];
  for (genvar i = 0; i < 3; i++) begin : g_dext
    assign dext[i] = EW'(dir_q[i]);
  end

  // valid bits
  logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, vld7_q, vld9_q, vld10_q;
  logic dv_q [QTW+1];

  // stage 1: edges and origin offset
  logic signed [EW-1:0] e1_1_q [3], e2_1_q [3], s_1_q [3];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      e1_1_q[i] <= EW'(v1[i]) - EW'(v0[i]);
      e2_1_q[i] <= EW'(v2[i]) - EW'(v0[i]);
      s_1_q[i]  <= EW'(org_q[i]) - EW'(v0[i]);
    end
  end

  // stage 2: cross product partials
  logic signed [PW-1:0] pd1_q [3], pd2_q [3], ps1_q [3], ps2_q [3];
  logic signed [EW-1:0] e1_2_q [3], e2_2_q [3], s_2_q [3];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pd1_q[i] <= PW'(dext[(i+1)%3] * e2_1_q[(i+2)%3]);
      pd2_q[i] <= PW'(dext[(i+2)%3] * e2_1_q[(i+1)%3]);
      ps1_q[i] <= PW'(s_1_q[(i+1)%3] * e1_1_q[(i+2)%3]);
      ps2_q[i] <= PW'(s_1_q[(i+2)%3] * e1_1_q[(i+1)%3]);
      e1_2_q[i] <= e1_1_q[i];
      e2_2_q[i] <= e2_1_q[i];
      s_2_q[i]  <= s_1_q[i];
    end
  end

  // stage 3: h = dir x e2, q = s x e1
  logic signed [HW-1:0] h_q [3], qv_q [3];
  logic signed [EW-1:0] e1_3_q [3], e2_3_q [3], s_3_q [3];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      h_q[i]    <= pd1_q[i] - pd2_q[i];
      qv_q[i]   <= ps1_q[i] - ps2_q[i];
      e1_3_q[i] <= e1_2_q[i];
      e2_3_q[i] <= e2_2_q[i];
      s_3_q[i]  <= s_2_q[i];
    end
  end

  // stage 4: dot product partials, wide operand split into high and low slices
  logic signed [PW-1:0] pl_q [4][3], ph_q [4][3];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pl_q[IdxA][i] <= PW'($signed({1'b0, h_q[i][LW-1:0]}) * e1_3_q[i]);
      ph_q[IdxA][i] <= PW'($signed(h_q[i][HW-1:LW]) * e1_3_q[i]);
      pl_q[IdxU][i] <= PW'($signed({1'b0, h_q[i][LW-1:0]}) * s_3_q[i]);
      ph_q[IdxU][i] <= PW'($signed(h_q[i][HW-1:LW]) * s_3_q[i]);
      pl_q[IdxV][i] <= PW'($signed({1'b0, qv_q[i][LW-1:0]}) * dext[i]);
      ph_q[IdxV][i] <= PW'($signed(qv_q[i][HW-1:LW]) * dext[i]);
      pl_q[IdxT][i] <= PW'($signed({1'b0, qv_q[i][LW-1:0]}) * e2_3_q[i]);
      ph_q[IdxT][i] <= PW'($signed(qv_q[i][HW-1:LW]) * e2_3_q[i]);
    end
  end

  // stage 5: recombine the slices
  logic signed [WW-1:0] prod_q [4][3];
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[k][i] <= (WW'(ph_q[k][i]) <<< LW) + WW'(pl_q[k][i]);
      end
    end
  end

  // stage 6: sums
  logic signed [WW-1:0] sum_q [4];
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      sum_q[k] <= prod_q[k][0] + prod_q[k][1] + prod_q[k][2];
    end
  end

  // stage 7: make the determinant non-negative, negating u, v and t with it
  logic signed [WW-1:0] adj_q [4];
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      adj_q[k] <= sum_q[IdxA][WW-1] ? -sum_q[k] : sum_q[k];
    end
  end

  // stage 8: inside tests and divider set-up
  logic signed [WW-1:0]         a7, u7, v7, t7;
  logic signed [WW:0]           uv7;
  logic [WW+EpsShift-1:0]       tsh7;
  logic [NW-1:0]                n7;
  logic [WW-1:0]                r0_7;
  logic                         hit7, sat7;
  always_comb begin
    a7   = adj_q[IdxA];
    u7   = adj_q[IdxU];
    v7   = adj_q[IdxV];
    t7   = adj_q[IdxT];
    uv7  = (WW+1)'(u7) + (WW+1)'(v7);
    tsh7 = {t7, {EpsShift{1'b0}}};
    n7   = {t7, {CoordFracBits{1'b0}}};
    r0_7 = WW'(n7[NW-1:QTW]);
    sat7 = r0_7 >= a7;
    hit7 = alg_q
        && (a7 >= (WW'(1) <<< (3 * CoordFracBits - EpsShift)))
        && !u7[WW-1] && (u7 <= a7)
        && !v7[WW-1] && (uv7 <= (WW+1)'(a7))
        && !t7[WW-1] && (tsh7 > (WW+EpsShift)'(a7));
  end

  div_t div_q [QTW+1];
  always_ff @(posedge clk_i) begin
    div_q[0].hit <= hit7;
    div_q[0].sat <= sat7;
    div_q[0].a   <= a7;
    div_q[0].r   <= sat7 ? '0 : r0_7;
    div_q[0].nlo <= n7[QTW-1:0];
    div_q[0].quo <= '0;
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < QTW; k++) begin : g_div
    logic [WW:0] r2;
    logic        ge;
    assign r2 = {div_q[k].r, div_q[k].nlo[QTW-1]};
    assign ge = r2 >= {1'b0, div_q[k].a};
    always_ff @(posedge clk_i) begin
      div_q[k+1].hit <= div_q[k].hit;
      div_q[k+1].sat <= div_q[k].sat;
      div_q[k+1].a   <= div_q[k].a;
      div_q[k+1].r   <= ge ? WW'(r2 - {1'b0, div_q[k].a}) : WW'(r2);
      div_q[k+1].nlo <= {div_q[k].nlo[QTW-2:0], 1'b0};
      div_q[k+1].quo <= {div_q[k].quo[QTW-2:0], ge};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else begin
        dv_q[k+1] <= dv_q[k];
      end
    end
  end

  // stage 9: t times direction partials
  logic [QTW-1:0]        tq;
  logic signed [MLW-1:0] ml_q [3];
  logic signed [MHW-1:0] mh_q [3];
  logic                  hit9_q;
  assign tq = div_q[QTW].sat ? {QTW{1'b1}} : div_q[QTW].quo;
  always_ff @(posedge clk_i) begin
    hit9_q <= div_q[QTW].hit;
    for (int i = 0; i < 3; i++) begin
      ml_q[i] <= MLW'($signed({1'b0, tq[TLW-1:0]}) * dir_q[i]);
      mh_q[i] <= MHW'($signed({1'b0, tq[QTW-1:TLW]}) * dir_q[i]);
    end
  end

  // stage 10: scale, offset by origin, saturate
  logic signed [PTW-1:0] pt [3];
  logic signed [CW-1:0]  sat_pt [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = ((PTW'(mh_q[i]) <<< TLW) + PTW'(ml_q[i])) >>> CoordFracBits;
      pt[i] = pt[i] + PTW'(org_q[i]);
      if (pt[i] < PTW'(-(64'sd1 <<< (CW - 1)))) begin
        sat_pt[i] = {1'b1, {(CW-1){1'b0}}};
      end else if (pt[i] > PTW'((64'sd1 <<< (CW - 1)) - 64'sd1)) begin
        sat_pt[i] = {1'b0, {(CW-1){1'b1}}};
      end else begin
        sat_pt[i] = pt[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_o <= 1'b0;
    end else begin
      hit_o <= vld9_q && hit9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_x_o <= (vld9_q && hit9_q) ? sat_pt[0] : '0;
    hit_y_o <= (vld9_q && hit9_q) ? sat_pt[1] : '0;
    hit_z_o <= (vld9_q && hit9_q) ? sat_pt[2] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q  <= 1'b0;
      vld2_q  <= 1'b0;
      vld3_q  <= 1'b0;
      vld4_q  <= 1'b0;
      vld5_q  <= 1'b0;
      vld6_q  <= 1'b0;
      vld7_q  <= 1'b0;
      dv_q[0] <= 1'b0;
      vld9_q  <= 1'b0;
      vld10_q <= 1'b0;
    end else begin
      vld1_q  <= accept;
      vld2_q  <= vld1_q;
      vld3_q  <= vld2_q;
      vld4_q  <= vld3_q;
      vld5_q  <= vld4_q;
      vld6_q  <= vld5_q;
      vld7_q  <= vld6_q;
      dv_q[0] <= vld7_q;
      vld9_q  <= dv_q[QTW];
      vld10_q <= vld9_q;
    end
  end

  assign done_o = vld10_q;

endmodule

>>> hdl/rti_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rti_checker
// Port-level checks of the intersector: latency, strobe and miss payload.
// ----------------------------------------------------------------------------
module rti_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic                         hit_o,
  input logic signed [rti_pkg::CW-1:0] hit_x_o,
  input logic signed [rti_pkg::CW-1:0] hit_y_o,
  input logic signed [rti_pkg::CW-1:0] hit_z_o
);
  import rti_pkg::*;

  // every accepted item yields its result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(Latency) done_o)
    else $error("result missing after accept");

  // no result without an item accepted at the matching edge
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without item");

  a_hit_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> done_o)
    else $error("hit outside result strobe");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (hit_x_o == 0 && hit_y_o == 0 && hit_z_o == 0))
    else $error("miss with nonzero point");

endmodule

bind ray_triangle_intersect_top rti_checker u_rti_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipelined ray/triangle intersector. Triangles
// are streamed in bursts against several ray settings and the hit flag and
// hit point of every result are compared with an exact wide-integer
// prediction worked out in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import rti_pkg::*;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [127:0]   wide_t;
  typedef struct packed {
    logic   hit;
    coord_t x;
    coord_t y;
    coord_t z;
  } hit_res_t;

  localparam int unsigned CycleLimit = 400000;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t tri_q [9] = '{default: '0};
  logic   done_o, hit_o;
  coord_t hit_x_o, hit_y_o, hit_z_o;
  logic   cfg_valid_i = 1'b0;
  logic   cfg_ready_o;
  logic [2:0]    cfg_index_i = '0;
  logic [CW-1:0] cfg_data_i = '0;

  // bench copy of the ray registers
  coord_t ray_org [3];
  coord_t ray_dir [3];
  logic   alg_mt;

  hit_res_t hits_pending [$];
  int unsigned mismatches = 0;
  int unsigned n_items = 0, n_hits = 0, n_results = 0;
  int unsigned burst_left = 0;
  longint unsigned cycles = 0;

  ray_triangle_intersect_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .v0_x_i      (tri_q[0]),
    .v0_y_i      (tri_q[1]),
    .v0_z_i      (tri_q[2]),
    .v1_x_i      (tri_q[3]),
    .v1_y_i      (tri_q[4]),
    .v1_z_i      (tri_q[5]),
    .v2_x_i      (tri_q[6]),
    .v2_y_i      (tri_q[7]),
    .v2_z_i      (tri_q[8]),
    .done_o      (done_o),
    .hit_o       (hit_o),
    .hit_x_o     (hit_x_o),
    .hit_y_o     (hit_y_o),
    .hit_z_o     (hit_z_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic wide_t ext(coord_t c);
    return {{96{c[CW-1]}}, c};
  endfunction

  function automatic coord_t sat_coord(wide_t w);
    if (w < -(wide_t'(1) <<< 31)) return coord_t'(32'h8000_0000);
    if (w > (wide_t'(1) <<< 31) - 1) return coord_t'(32'h7fff_ffff);
    return w[CW-1:0];
  endfunction

  // exact determinant and barycentric tests, t quantised only for the point
  function automatic hit_res_t predict_hit(coord_t v [9]);
    wide_t e1 [3], e2 [3], s [3], d [3], o [3], h [3], q [3];
    wide_t det, bu, bv, bt, tq, p;
    hit_res_t res;
    int j, k;
    res = '0;
    if (!alg_mt) return res;
    for (int i = 0; i < 3; i++) begin
      o[i]  = ext(ray_org[i]);
      d[i]  = ext(ray_dir[i]);
      e1[i] = ext(v[3+i]) - ext(v[i]);
      e2[i] = ext(v[6+i]) - ext(v[i]);
      s[i]  = o[i] - ext(v[i]);
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      h[i] = d[j] * e2[k] - d[k] * e2[j];
      q[i] = s[j] * e1[k] - s[k] * e1[j];
    end
    det = 0; bu = 0; bv = 0; bt = 0;
    for (int i = 0; i < 3; i++) begin
      det += h[i] * e1[i];
      bu  += h[i] * s[i];
      bv  += q[i] * d[i];
      bt  += q[i] * e2[i];
    end
    if (det < 0) begin
      det = -det; bu = -bu; bv = -bv; bt = -bt;
    end
    if (det < (wide_t'(1) <<< (3 * CoordFracBits - EpsShift))) return res;
    if (bu < 0 || bu > det) return res;
    if (bv < 0 || bu + bv > det) return res;
    if (bt < 0 || (bt <<< EpsShift) <= det) return res;
    tq = (bt <<< CoordFracBits) / det;
    if (tq > (wide_t'(1) <<< 63) - 1) tq = (wide_t'(1) <<< 63) - 1;
    res.hit = 1'b1;
    p = ((tq * d[0]) >>> CoordFracBits) + o[0];
    res.x = sat_coord(p);
    p = ((tq * d[1]) >>> CoordFracBits) + o[1];
    res.y = sat_coord(p);
    p = ((tq * d[2]) >>> CoordFracBits) + o[2];
    res.z = sat_coord(p);
    return res;
  endfunction

  // accept side queues the prediction, result side pops and compares
  always @(posedge clk_i) begin
    hit_res_t want;
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      if (rst_ni && done_o) begin
        n_results <= n_results + 1;
        if (hits_pending.size() == 0) begin
          $error("result with no item outstanding");
          mismatches <= mismatches + 1;
        end else begin
          want = hits_pending.pop_front();
          if (hit_o !== want.hit || hit_x_o !== want.x || hit_y_o !== want.y ||
              hit_z_o !== want.z) begin
            mismatches <= mismatches + 1;
            if (hit_o !== want.hit) $error("hit exp %0d got %0d", want.hit, hit_o);
            if (hit_x_o !== want.x) $error("hit_x exp %0d got %0d", want.x, hit_x_o);
            if (hit_y_o !== want.y) $error("hit_y exp %0d got %0d", want.y, hit_y_o);
            if (hit_z_o !== want.z) $error("hit_z exp %0d got %0d", want.z, hit_z_o);
          end
        end
      end
      if (rst_ni && start && !busy) begin
        want = predict_hit(tri_q);
        hits_pending = {hits_pending, want};
        n_items <= n_items + 1;
        if (want.hit) n_hits <= n_hits + 1;
      end
    end
  end

  task automatic send_triangle(coord_t v [9]);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    for (int i = 0; i < 9; i++) tri_q[i] <= v[i];
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // sender holds off until the pipeline is empty
  task automatic drain;
    start <= 1'b0;
    @(posedge clk_i);
    while (hits_pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgOrgX, CfgOrgY, CfgOrgZ: ray_org[idx] = val;
      CfgDirX, CfgDirY, CfgDirZ: ray_dir[idx - CfgDirX] = val;
      CfgAlgSel:                 alg_mt = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_ray(coord_t o [3], coord_t d [3]);
    cfg_write(CfgOrgX, o[0]);
    cfg_write(CfgOrgY, o[1]);
    cfg_write(CfgOrgZ, o[2]);
    cfg_write(CfgDirX, d[0]);
    cfg_write(CfgDirY, d[1]);
    cfg_write(CfgDirZ, d[2]);
  endtask

  function automatic coord_t rnd_coord(int amp);
    wide_t w;
    w = ext($urandom) >>> (32 - amp);
    return w[CW-1:0];
  endfunction

  // most triangles are built round a point on the ray so hits are common
  task automatic random_triangle(output coord_t v [9]);
    int sel, amp, sh;
    wide_t tgt [3];
    sel = $urandom_range(0, 99);
    sh  = $urandom_range(0, 20);
    amp = $urandom_range(4, 28);
    for (int i = 0; i < 3; i++)
      tgt[i] = ext(ray_org[i]) +
               ((ext(ray_dir[i]) * wide_t'($urandom_range(1, 4096))) >>> sh);
    for (int i = 0; i < 9; i++) begin
      if (sel < 65)      v[i] = sat_coord(tgt[i % 3] + ext(rnd_coord(amp)));
      else if (sel < 82) v[i] = $urandom;
      else               v[i] = sat_coord(tgt[i % 3] + ext(rnd_coord(amp)));
    end
    // degenerate: repeated vertex or collinear edge
    if (sel >= 82 && sel < 91) begin
      for (int i = 0; i < 3; i++) v[3+i] = v[i];
    end else if (sel >= 91) begin
      for (int i = 0; i < 3; i++)
        v[6+i] = sat_coord(2 * ext(v[3+i]) - ext(v[i]));
    end
  endtask

  task automatic run_random(int unsigned count);
    coord_t v [9];
    repeat (count) begin
      random_triangle(v);
      send_triangle(v);
    end
  endtask

  task automatic test_directed;
    localparam coord_t One = 32'sh0001_0000;
    coord_t v [9];
    // plane x = 2 spanning the x axis
    v = '{2*One, -One, -One, 2*One, 3*One, -One, 2*One, -One, 3*One};
    send_triangle(v);
    // same triangle behind the origin
    v = '{-2*One, -One, -One, -2*One, 3*One, -One, -2*One, -One, 3*One};
    send_triangle(v);
    // ray passes through a vertex, u and v on the boundary
    v = '{2*One, 0, 0, 2*One, One, 0, 2*One, 0, One};
    send_triangle(v);
    // u exactly one and v below zero
    v = '{2*One, One, 0, 2*One, 0, One, 2*One, One, One};
    send_triangle(v);
    // triangle off to the side: u out, then v out
    v = '{2*One, One, One, 2*One, 3*One, One, 2*One, One, 3*One};
    send_triangle(v);
    v = '{2*One, -3*One, One, 2*One, -One, One, 2*One, -One, 3*One};
    send_triangle(v);
    // plane parallel to the ray
    v = '{0, One, -One, 4*One, One, -One, 0, One, One};
    send_triangle(v);
    // degenerate, all vertices equal
    v = '{default: 2*One};
    send_triangle(v);
    // t just about epsilon
    v = '{1, -One, -One, 1, 3*One, -One, 1, -One, 3*One};
    send_triangle(v);
    v = '{0, -One, -One, 0, 3*One, -One, 0, -One, 3*One};
    send_triangle(v);
    // field extremes
    v = '{default: 32'sh7fff_ffff};
    send_triangle(v);
    v = '{default: 32'sh8000_0000};
    send_triangle(v);
    v = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
          32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
          32'sh7fff_ffff};
    send_triangle(v);
    v = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
          32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
          32'sh8000_0000};
    send_triangle(v);
    drain();
  endtask

  task automatic test_reset_ray;
    run_random(350);
    drain();
  endtask

  task automatic test_random_ray;
    coord_t o [3], d [3];
    for (int i = 0; i < 3; i++) begin
      o[i] = rnd_coord(22);
      d[i] = rnd_coord(19);
    end
    set_ray(o, d);
    cfg_write(CfgAlgSel, 32'd1);
    run_random(400);
    drain();
  endtask

  task automatic test_extreme_ray;
    coord_t o [3], d [3];
    o = '{32'sh7fff_ffff, 32'sh8000_0000, 0};
    d = '{32'sh7fff_ffff, 32'sh8000_0000, 1};
    set_ray(o, d);
    run_random(150);
    drain();
    o = '{32'sh8000_0000, 0, 32'sh7fff_ffff};
    d = '{32'sh8000_0000, 1, 32'sh7fff_ffff};
    set_ray(o, d);
    run_random(100);
    drain();
  endtask

  task automatic test_alg_off;
    // only bit zero of the select counts, and a write to the unused index is dropped
    cfg_write(CfgAlgSel, 32'd2);
    cfg_write(CfgNone, 32'hffff_ffff);
    run_random(150);
    drain();
    cfg_write(CfgAlgSel, 32'hffff_ffff);
  endtask

  task automatic test_tiny_dir;
    coord_t o [3], d [3];
    // long hit distances, t saturation
    o = '{rnd_coord(20), rnd_coord(20), rnd_coord(20)};
    d = '{1, 32'shffff_ffff, 0};
    set_ray(o, d);
    run_random(250);
    drain();
  endtask

  task automatic test_full_ray;
    coord_t o [3], d [3];
    for (int i = 0; i < 3; i++) begin
      o[i] = $urandom;
      d[i] = $urandom;
    end
    set_ray(o, d);
    run_random(200);
    drain();
  endtask

  initial begin
    ray_org = '{0, 0, 0};
    ray_dir = '{32'sh0001_0000, 0, 0};
    alg_mt  = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_reset_ray();
    test_random_ray();
    test_extreme_ray();
    test_alg_off();
    test_tiny_dir();
    test_full_ray();
    $display("covered %0d triangles, %0d hits, over default, random, extreme,",
             n_items, n_hits);
    $display("disabled and tiny-direction ray settings; %0d results seen", n_results);
    if (mismatches == 0 && hits_pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
